// File: hw/rtl/cdq_pkg.sv
// Shared types, constants and ring-pointer helpers for the circular deque.
package cdq_pkg;

    localparam int DEPTH     = 128;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 8;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_REAR  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_REAR   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
    } cdq_cmd_t;

    function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] p);
        ring_next = (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] ring_prev(input logic [ADDR_W-1:0] p);
        ring_prev = (p == '0) ? ADDR_W'(DEPTH - 1) : p - 1'b1;
    endfunction

endpackage

// File: hw/rtl/cdq_ctrl.sv
// Controller state machine: sequences capture, execute and result handoff.
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output cdq_cmd_t cmd
);

    typedef enum logic [1:0] {
        IDLE,
        EXEC,
        RESP
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd.capture   = 1'b0;
        cmd.exec      = 1'b0;
        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = EXEC;
                end
            end
            EXEC: begin
                cmd.exec      = 1'b1;
                m_tvalid_next = 1'b1;
                state_next    = RESP;
            end
            RESP: begin
                // hold the result until the transaction completes
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    state_next    = IDLE;
                end
            end
            default: begin
                state_next    = IDLE;
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// File: hw/rtl/cdq_datapath.sv
// Datapath: word store, head/tail pointers, count and result registers.
module cdq_datapath
    import cdq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cdq_cmd_t          cmd,
    input  logic [1:0]        req_in,
    input  logic [WORD_W-1:0] data_in,
    output logic [1:0]        status_out,
    output logic [WORD_W-1:0] popped_out,
    output logic [COUNT_W-1:0] count_out,
    output logic              empty_out,
    output logic              full_out
);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [1:0]        req_reg;
    logic [WORD_W-1:0] data_reg;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] rd_data_reg;
    logic              pop_ok_reg;
    logic [1:0]        status_reg, status_next;

    logic              is_push, is_front, is_empty, is_full;
    logic              push_ok, pop_ok;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    always_comb begin
        is_push  = (req_reg == REQ_PUSH_FRONT) || (req_reg == REQ_PUSH_REAR);
        is_front = (req_reg == REQ_PUSH_FRONT) || (req_reg == REQ_POP_FRONT);
        is_empty = (count_reg == '0);
        is_full  = (count_reg == CNT_W'(DEPTH));
        push_ok  = is_push && !is_full;
        pop_ok   = !is_push && !is_empty;

        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        wr_addr     = '0;
        rd_addr     = is_front ? head_reg : tail_reg;
        status_next = ST_DONE;

        if (is_push) begin
            if (is_full) begin
                status_next = ST_OVERFLOW;
            end else begin
                if (is_empty) begin
                    head_next = '0;
                    tail_next = '0;
                    wr_addr   = '0;
                end else if (is_front) begin
                    head_next = ring_prev(head_reg);
                    wr_addr   = head_next;
                end else begin
                    tail_next = ring_next(tail_reg);
                    wr_addr   = tail_next;
                end
                count_next = count_reg + 1'b1;
            end
        end else begin
            if (is_empty) begin
                status_next = ST_UNDERFLOW;
            end else begin
                // last word out: rewind both pointers
                if (count_reg == CNT_W'(1)) begin
                    head_next = '0;
                    tail_next = '0;
                end else if (is_front) begin
                    head_next = ring_next(head_reg);
                end else begin
                    tail_next = ring_prev(tail_reg);
                end
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && push_ok) begin
            mem[wr_addr] <= data_reg;
        end
        if (cmd.exec) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg  <= req_in;
            data_reg <= data_in;
        end
        if (cmd.exec) begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            pop_ok_reg <= 1'b0;
        end else if (cmd.exec) begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            pop_ok_reg <= pop_ok;
        end
    end

    assign status_out = status_reg;
    assign popped_out = pop_ok_reg ? rd_data_reg : '0;
    assign count_out  = COUNT_W'(count_reg);
    assign empty_out  = (count_reg == '0);
    assign full_out   = (count_reg == CNT_W'(DEPTH));

endmodule

// File: hw/rtl/circular_deque.sv
// The input transaction is captured, then executed, and the registered result is offered
// in RESP. One request is in flight at a time, set by the controller's capture, execute
// and respond sequence; a new request is accepted only after the output handshake.
// Reset: aresetn synchronous active low; clears pointers, count and handshake state.
// The word store is not cleared; popped_value is zero unless a pop succeeded, so stale words never reach m_tdata.
// Top level of the circular deque.
module circular_deque
    import cdq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] data_value
    input  logic [1:0]           s_tuser,   // [1:0] req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] popped_value, [39:32] entry_count,
                                            // [40] is_empty, [41] is_full, [47:42] zero
    output logic [1:0]           m_tuser    // [1:0] status
);

    cdq_cmd_t           cmd;
    logic [1:0]         status;
    logic [WORD_W-1:0]  popped_value;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic               is_full;

    cdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    cdq_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .req_in     (s_tuser),
        .data_in    (s_tdata[WORD_W-1:0]),
        .status_out (status),
        .popped_out (popped_value),
        .count_out  (entry_count),
        .empty_out  (is_empty),
        .full_out   (is_full)
    );

    assign m_tdata = {6'd0, is_full, is_empty, entry_count, popped_value};
    assign m_tuser = status;

endmodule

// File: sim/cdq_checker.sv
// Checker for the circular deque: predicts each response and compares it with the DUT.
module cdq_checker
    import cdq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] data_value
    input  logic [1:0]           s_tuser,   // [1:0] req_type
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // [31:0] popped_value, [39:32] entry_count,
                                            // [40] is_empty, [41] is_full, [47:42] zero
    input  logic [1:0]           m_tuser,   // [1:0] status
    output int                   fail_count,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        status_t             status;
        logic [WORD_W-1:0]   popped;
        logic [COUNT_W-1:0]  count;
        logic                empty;
        logic                full;
    } deque_resp_t;

    // Shadow copy of the deque contents and pointers.
    logic [WORD_W-1:0] shadow_words [DEPTH];
    int                front_pos;
    int                rear_pos;
    int                words_held;
    int                err_cnt;
    deque_resp_t       resp_q [$];
    deque_resp_t       exp_resp;
    deque_resp_t       got_resp;

    assign fail_count = err_cnt;

    initial begin
        err_cnt     = 0;
        outstanding = 0;
        front_pos   = 0;
        rear_pos    = 0;
        words_held  = 0;
    end

    function automatic deque_resp_t apply_request(req_t op, logic [WORD_W-1:0] word);
        deque_resp_t r;
        r        = '0;
        r.status = ST_DONE;
        if (op == REQ_PUSH_FRONT || op == REQ_PUSH_REAR) begin
            if (words_held == DEPTH) begin
                r.status = ST_OVERFLOW;
            end else begin
                if (words_held == 0) begin
                    // first word always lands at entry zero
                    front_pos       = 0;
                    rear_pos        = 0;
                    shadow_words[0] = word;
                end else if (op == REQ_PUSH_FRONT) begin
                    front_pos               = (front_pos + DEPTH - 1) % DEPTH;
                    shadow_words[front_pos] = word;
                end else begin
                    rear_pos               = (rear_pos + 1) % DEPTH;
                    shadow_words[rear_pos] = word;
                end
                words_held++;
            end
        end else if (words_held == 0) begin
            r.status = ST_UNDERFLOW;
        end else begin
            r.popped = (op == REQ_POP_FRONT) ? shadow_words[front_pos] : shadow_words[rear_pos];
            if (words_held == 1) begin
                front_pos = 0;
                rear_pos  = 0;
            end else if (op == REQ_POP_FRONT) begin
                front_pos = (front_pos + 1) % DEPTH;
            end else begin
                rear_pos = (rear_pos + DEPTH - 1) % DEPTH;
            end
            words_held--;
        end
        r.count = COUNT_W'(words_held);
        r.empty = (words_held == 0);
        r.full  = (words_held == DEPTH);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            front_pos  = 0;
            rear_pos   = 0;
            words_held = 0;
            resp_q.delete();
        end else begin
            // retire the response before queuing a new request; responses lag requests
            if (m_tvalid && m_tready) begin
                got_resp.status = status_t'(m_tuser);
                got_resp.popped = m_tdata[31:0];
                got_resp.count  = m_tdata[39:32];
                got_resp.empty  = m_tdata[40];
                got_resp.full   = m_tdata[41];
                if (resp_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: stray response st=%0d pop=%h cnt=%0d e=%0b f=%0b",
                                 $realtime, got_resp.status, got_resp.popped, got_resp.count,
                                 got_resp.empty, got_resp.full);
                end else begin
                    exp_resp = resp_q.pop_front();
                    if (got_resp !== exp_resp) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS) begin
                            $display("%0t: mismatch exp st=%0d pop=%h cnt=%0d e=%0b f=%0b",
                                     $realtime, exp_resp.status, exp_resp.popped,
                                     exp_resp.count, exp_resp.empty, exp_resp.full);
                            $display("%0t: mismatch got st=%0d pop=%h cnt=%0d e=%0b f=%0b",
                                     $realtime, got_resp.status, got_resp.popped,
                                     got_resp.count, got_resp.empty, got_resp.full);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                resp_q.push_back(apply_request(req_t'(s_tuser), s_tdata));
        end
        outstanding <= resp_q.size();
    end

endmodule

// File: sim/circular_deque_tb.sv
// Testbench top for the circular deque: clock, reset, request stimulus and verdict.
module circular_deque_tb;
    import cdq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQS  = 1850;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 16;
    localparam int READY_ALWAYS = 0;
    localparam int READY_MOSTLY = 1;
    localparam int READY_RARELY = 2;
    localparam int PCT_FILL     = 92;
    localparam int PCT_DRAIN    = 8;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [31:0] data_value
    logic [1:0]           s_tuser  = '0;   // [1:0] req_type
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [31:0] popped_value, [39:32] entry_count,
                                           // [40] is_empty, [41] is_full, [47:42] zero
    logic [1:0]           m_tuser;         // [1:0] status

    int fail_count;
    int outstanding;
    int burst_left = 0;
    int ready_mode = READY_ALWAYS;
    int ready_left = 0;

    circular_deque i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cdq_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Receiver backpressure: switch between ready patterns every so often.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(READY_ALWAYS, READY_RARELY);
            ready_left = $urandom_range(40, 160);
        end
        ready_left--;
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_MOSTLY: m_tready <= ($urandom_range(0, 9) < 7);
            default:      m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Send one request transaction; open a new burst after a random gap when the last one ends.
    task automatic issue(req_t op, logic [WORD_W-1:0] word);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold off the sender until every queued response has been returned or the DRAIN_LIMIT guard runs out.
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t pick_op(int push_pct);
        logic at_front;
        at_front = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < push_pct)
            return at_front ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
        return at_front ? REQ_POP_FRONT : REQ_POP_REAR;
    endfunction

    initial begin
        int sent;
        int seg;
        int seg_len;
        int push_pct;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: underflow on empty, extreme words, wrap below entry zero, last-word pops.
        issue(REQ_POP_FRONT,  32'h0);
        issue(REQ_POP_REAR,   32'hDEAD_BEEF);
        issue(REQ_PUSH_REAR,  32'h7FFF_FFFF);
        issue(REQ_PUSH_FRONT, 32'h8000_0000);
        issue(REQ_PUSH_REAR,  32'h0000_0000);
        issue(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
        issue(REQ_PUSH_REAR,  32'h5555_5555);
        issue(REQ_PUSH_FRONT, 32'hAAAA_AAAA);
        issue(REQ_POP_FRONT,  32'h0);
        issue(REQ_POP_REAR,   32'h0);
        issue(REQ_POP_FRONT,  32'h0);
        issue(REQ_POP_REAR,   32'h0);
        issue(REQ_POP_FRONT,  32'h0);
        issue(REQ_POP_REAR,   32'h0);
        issue(REQ_POP_REAR,   32'h0);
        issue(REQ_PUSH_FRONT, 32'h1234_5678);
        issue(REQ_POP_FRONT,  32'h0);
        issue(REQ_PUSH_FRONT, 32'h0000_0001);
        issue(REQ_PUSH_FRONT, 32'h0000_0002);
        issue(REQ_POP_REAR,   32'h0);
        issue(REQ_POP_REAR,   32'h0);
        issue(REQ_POP_FRONT,  32'h0);
        wait_drained();

        // Random: segments biased to fill to overflow, drain to underflow, or churn in between.
        sent = 0;
        seg  = 0;
        while (sent < RANDOM_REQS) begin
            case (seg)
                0:       push_pct = PCT_FILL;
                1:       push_pct = PCT_DRAIN;
                default: begin
                    case ($urandom_range(0, 4))
                        0:       push_pct = PCT_FILL;
                        1:       push_pct = PCT_DRAIN;
                        2:       push_pct = 50;
                        3:       push_pct = 65;
                        default: push_pct = 35;
                    endcase
                end
            endcase
            seg_len = $urandom_range(60, 220);
            while (seg_len > 0 && sent < RANDOM_REQS) begin
                issue(pick_op(push_pct), pick_word());
                seg_len--;
                sent++;
            end
            seg++;
            if (seg == 4)
                wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
